// ===== rtl/core/hs_pkg.sv =====
// Shared types and constants for the heap sorter cell chain.
package hs_pkg;

    localparam int DATA_W = 32;

    // Contents of one cell: an occupancy flag and the held element.
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] val;
    } cell_t;

    // Chain-wide command, the same for every cell in a cycle.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/hs_cell.sv =====
// One cell of the sorting chain: holds one element and trades with its neighbors.
module hs_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  hs_pkg::cell_ctrl_t                ctrl,
    input  logic signed [hs_pkg::DATA_W-1:0]  new_val,
    input  hs_pkg::cell_t                     left,
    input  logic                              left_take,
    input  hs_pkg::cell_t                     right,
    output logic                              take,
    output hs_pkg::cell_t                     cur
);
    import hs_pkg::*;

    logic                     occ_reg;
    logic                     occ_next;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;

    // The new element belongs at or before this cell when it is smaller
    // than what is held here, or when the cell is empty.
    assign take = ctrl.insert && (!occ_reg || (new_val < val_reg));

    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        if (ctrl.shift)
        begin
            occ_next = right.occ;
            val_next = right.val;
        end
        else if (take)
        begin
            if (left_take)
            begin
                occ_next = left.occ;
                val_next = left.val;
            end
            else
            begin
                occ_next = 1'b1;
                val_next = new_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign cur.occ = occ_reg;
    assign cur.val = val_reg;

endmodule

// ===== rtl/core/heap_sorter_unit.sv =====
// Top level of the sorter: a chain of insertion cells and a registered output stage.
//
// Usage: elements of a set arrive on the slave stream, one signed 32-bit value per
// transaction, with tlast marking the final element of the set. An element that fills
// the chain (MAX_ITEMS elements held) also closes the set. While a set is loading, one
// element is taken every cycle; the chain keeps the elements in ascending order as they
// arrive, with each cell comparing the new value against its own in parallel.
// Once the set is closed, s_axis_tready drops and the chain drains toward cell zero,
// one element per cycle while the receiver keeps up, into the output register. The
// master stream delivers the set in ascending order, with tlast on the largest element.
// The closing transaction moves the state register to drain, and the first result is
// then registered in the output register. A new set is not taken while one drains:
// the state returns to load as the last result is registered, and the next set is
// accepted from then on.
// Reset clears every cell's occupancy flag and the output valid; no clearing pass
// is needed. When the receiver stalls, the output register holds its transaction
// and the chain stops shifting until it is taken.
module heap_sorter_unit
#(
    parameter int MAX_ITEMS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hs_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic                          s_axis_tlast,   // is_last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hs_pkg::DATA_W-1:0]     m_axis_tdata,   // [31:0] sorted_value
    output logic                          m_axis_tlast    // end_of_set
);
    import hs_pkg::*;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    cell_ctrl_t          ctrl;
    cell_t               cells [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] takes;
    logic [MAX_ITEMS-1:0] occ_vec;
    cell_t               empty_cell;

    logic in_fire;
    logic pop;
    logic closing;

    assign empty_cell.occ = 1'b0;
    assign empty_cell.val = '0;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // The set closes on tlast or when this element takes the last free cell.
    assign closing = s_axis_tlast || occ_vec[MAX_ITEMS-2];

    // Draining moves one element out whenever the output register is free.
    assign pop = (state_reg == ST_DRAIN) && (!out_valid_reg || m_axis_tready);

    assign ctrl.insert = in_fire;
    assign ctrl.shift  = pop;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            hs_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_val   ($signed(s_axis_tdata)),
                .left      ((gi == 0) ? empty_cell : cells[(gi == 0) ? 0 : gi-1]),
                .left_take ((gi == 0) ? 1'b0 : takes[(gi == 0) ? 0 : gi-1]),
                .right     ((gi == MAX_ITEMS-1) ? empty_cell
                                : cells[(gi == MAX_ITEMS-1) ? gi : gi+1]),
                .take      (takes[gi]),
                .cur       (cells[gi])
            );
            assign occ_vec[gi] = cells[gi].occ;
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && closing)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The element leaving now is the last one when cell one is empty.
                if (pop && !occ_vec[1])
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= cells[0].val;
            out_last_reg <= !occ_vec[1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    // While draining, the head cell always holds the next element to send.
    a_drain_head_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> occ_vec[0])
        else $error("drain state with empty head cell");

    // Occupied cells always form an unbroken run starting at cell zero.
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec & (occ_vec + MAX_ITEMS'(1))) == '0))
        else $error("cell occupancy has a gap");

    // Sending the final element leaves the chain empty and ready to load.
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !occ_vec[1]) |=> (occ_vec == '0) && (state_reg == ST_LOAD)
            && m_axis_tvalid && m_axis_tlast)
        else $error("chain not empty after the last element was sent");
`endif

endmodule
